FILE: rtl/trp_pkg.sv
// ----------------------------------------------------------------------------
// trp_pkg - shared types and constants for the text record parser
// Parser state, result record, stream codes and the code page remap.
// ----------------------------------------------------------------------------
package trp_pkg;

    localparam int NAME_ENTRIES     = 20;
    localparam int DIALOGUE_ENTRIES = 50;

    localparam logic [7:0] CODE_END_SECTION = 8'hF6;
    localparam logic [7:0] CODE_NEXT_ENTRY  = 8'hF4;

    // parse phases
    localparam logic [1:0] PH_CODE  = 2'd0;
    localparam logic [1:0] PH_LEN   = 2'd1;
    localparam logic [1:0] PH_CHARS = 2'd2;

    // sections
    localparam logic [1:0] SEC_NAME     = 2'd0;
    localparam logic [1:0] SEC_DIALOGUE = 2'd1;
    localparam logic [1:0] SEC_DONE     = 2'd2;

    // entry counter codes
    localparam logic [6:0] ENTRY_NONE = 7'd127;
    localparam logic [6:0] ENTRY_SAT  = 7'd64;

    localparam logic [6:0] NAME_LIMIT     = 7'(NAME_ENTRIES);
    localparam logic [6:0] DIALOGUE_LIMIT = 7'(DIALOGUE_ENTRIES);

    // result kinds
    localparam logic [1:0] KIND_CHAR     = 2'd0;
    localparam logic [1:0] KIND_END      = 2'd1;
    localparam logic [1:0] KIND_MISSING  = 2'd2;
    localparam logic [1:0] KIND_OVERFLOW = 2'd3;

    typedef struct packed {
        logic [1:0] phase;
        logic [1:0] section;
        logic [6:0] entry;
        logic [7:0] chars_left;
        logic [7:0] position;
        logic       dropped;
    } parse_state_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       section;
        logic [5:0] entry;
        logic [7:0] position;
        logic [7:0] char_out;
        logic       last_char;
    } result_t;

    function automatic logic [7:0] remap_char(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if ((c >= 8'hAE && c <= 8'hC7) || (c >= 8'hCE && c <= 8'hE7)) begin
            r = c - 8'h6D;
        end else begin
            unique case (c)
                8'hE8:   r = 8'hA0;
                8'hE9:   r = 8'h82;
                8'hEA:   r = 8'hA1;
                8'hEB:   r = 8'hA2;
                8'hEC:   r = 8'hA3;
                8'hED:   r = 8'hA4;
                8'hEE:   r = 8'hA5;
                default: r = c;
            endcase
        end
        return r;
    endfunction

    function automatic parse_state_t start_state(input logic skip);
        parse_state_t s;
        s.phase      = PH_CODE;
        s.section    = skip ? SEC_DIALOGUE : SEC_NAME;
        s.entry      = skip ? 7'd0 : ENTRY_NONE;
        s.chars_left = 8'd0;
        s.position   = 8'd0;
        s.dropped    = 1'b0;
        return s;
    endfunction

endpackage

FILE: rtl/text_record_parser_remap_top.sv
// ----------------------------------------------------------------------------
// text_record_parser_remap_top - sectioned string record parser with remap
// Path: input register, parse step, then result register on the m_ side.
// Throughput: one transaction per cycle unless m_ready stalls the result,
//   set by the combinational parse step between the two registers.
// Reset: aresetn (synchronous, active low) clears both stages, clears
//   skip_name_section and starts parsing in the name section.
// ----------------------------------------------------------------------------
module text_record_parser_remap_top (
    input  logic       aclk,
    input  logic       aresetn,
    // configuration
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    // input stream
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_op,
    input  logic [7:0] s_in_byte,
    // result stream
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_kind,
    output logic       m_section,
    output logic [5:0] m_entry,
    output logic [7:0] m_position,
    output logic [7:0] m_char_out,
    output logic       m_last_char
);
    import trp_pkg::*;

    // skip_name_section register: only read at restart
    logic skip_reg;

    // input stage
    logic       in_valid_reg;
    logic       in_op_reg;
    logic [7:0] in_byte_reg;

    // parser state, lives alongside the result register
    parse_state_t state_reg;
    parse_state_t state_next;

    // result stage
    logic    out_valid_reg;
    result_t out_reg;

    logic    res_valid;
    result_t res;
    logic    advance;

    // The input stage moves on whenever the result register is free or is
    // being emptied this cycle. A result held by m_ready low stalls the step,
    // and s_ready drops only once the input register is full as well.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    trp_step u_step (
        .state      (state_reg),
        .skip       (skip_reg),
        .op         (in_op_reg),
        .in_byte    (in_byte_reg),
        .state_next (state_next),
        .res_valid  (res_valid),
        .res        (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_reg <= 1'b0;
        end else if (cfg_we) begin
            skip_reg <= cfg_wdata;
        end
    end

    // input register: control is reset, payload is not
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_op_reg   <= s_op;
            in_byte_reg <= s_in_byte;
        end
    end

    // parser state advances once per processed transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= start_state(1'b0);
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // result register: filled on a producing step, emptied on handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= res_valid;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_kind      = out_reg.kind;
    assign m_section   = out_reg.section;
    assign m_entry     = out_reg.entry;
    assign m_position  = out_reg.position;
    assign m_char_out  = out_reg.char_out;
    assign m_last_char = out_reg.last_char;

endmodule

FILE: rtl/trp_step.sv
// ----------------------------------------------------------------------------
// trp_step - per-byte parse step
// Next parser state and the optional result for one stream transaction.
// ----------------------------------------------------------------------------
module trp_step (
    input  trp_pkg::parse_state_t state,
    input  logic                  skip,
    input  logic                  op,
    input  logic [7:0]            in_byte,
    output trp_pkg::parse_state_t state_next,
    output logic                  res_valid,
    output trp_pkg::result_t      res
);
    import trp_pkg::*;

    logic [6:0] limit;
    logic       last;

    assign limit = (state.section == SEC_NAME) ? NAME_LIMIT : DIALOGUE_LIMIT;
    assign last  = (state.chars_left <= 8'd1);

    always_comb begin
        state_next    = state;
        res_valid     = 1'b0;
        res.kind      = KIND_CHAR;
        res.section   = state.section[0];
        res.entry     = (state.entry == ENTRY_NONE) ? 6'd0 : state.entry[5:0];
        res.position  = 8'd0;
        res.char_out  = 8'd0;
        res.last_char = 1'b0;

        if (!op) begin
            state_next = start_state(skip);
        end else if (state.section != SEC_DONE) begin
            unique case (state.phase)
                PH_CODE: begin
                    if (in_byte == CODE_END_SECTION) begin
                        if (state.section == SEC_NAME) begin
                            state_next.section = SEC_DIALOGUE;
                            state_next.entry   = 7'd0;
                        end else begin
                            res_valid          = 1'b1;
                            res.kind           = KIND_END;
                            state_next.section = SEC_DONE;
                        end
                    end else begin
                        if (in_byte == CODE_NEXT_ENTRY) begin
                            if (state.entry == ENTRY_NONE) begin
                                state_next.entry = 7'd0;
                            end else if (state.entry < ENTRY_SAT) begin
                                state_next.entry = state.entry + 7'd1;
                            end
                        end
                        state_next.phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    if (in_byte == 8'd0) begin
                        state_next.phase = PH_CODE;
                    end else begin
                        state_next.chars_left = in_byte;
                        state_next.position   = 8'd0;
                        state_next.dropped    = 1'b0;
                        state_next.phase      = PH_CHARS;
                        if (state.entry == ENTRY_NONE) begin
                            state_next.dropped = 1'b1;
                            res_valid          = 1'b1;
                            res.kind           = KIND_MISSING;
                        end else if (state.entry >= limit) begin
                            state_next.dropped = 1'b1;
                            res_valid          = 1'b1;
                            res.kind           = KIND_OVERFLOW;
                        end
                    end
                end
                default: begin
                    // character byte
                    if (!state.dropped) begin
                        res_valid     = 1'b1;
                        res.kind      = KIND_CHAR;
                        res.position  = state.position;
                        res.char_out  = remap_char(in_byte);
                        res.last_char = last;
                    end
                    if (last) begin
                        state_next.chars_left = 8'd0;
                        state_next.position   = 8'd0;
                        state_next.dropped    = 1'b0;
                        state_next.phase      = PH_CODE;
                    end else begin
                        state_next.chars_left = state.chars_left - 8'd1;
                        state_next.position   = state.position + 8'd1;
                    end
                end
            endcase
        end
    end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - testbench for text_record_parser_remap_top
// A short table of hand-picked bytes is followed by randomly built record
// streams across both settings of skip_name_section. Bytes go in on the s_
// side and results are checked on the m_ side against an in-bench parser.
// Both sides idle at random, except in one phase that runs with no idling.
// ----------------------------------------------------------------------------
module tb;
    import trp_pkg::*;

    localparam int PHASE_QUOTA = 150;     // counted input transactions per phase
    localparam int CYCLE_LIMIT = 100000;  // hard stop, well above a slow clean run
    localparam int SETTLE      = 4;       // extra wait in drain once nothing is owed

    // ------------------------------------------------------------------
    // DUT connections; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       cfg_we      = 1'b0;
    logic       cfg_wdata   = 1'b0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    logic       s_op        = 1'b0;
    logic [7:0] s_in_byte   = 8'h00;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    logic [1:0] m_kind;
    logic       m_section;
    logic [5:0] m_entry;
    logic [7:0] m_position;
    logic [7:0] m_char_out;
    logic       m_last_char;

    text_record_parser_remap_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_in_byte   (s_in_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_section   (m_section),
        .m_entry     (m_entry),
        .m_position  (m_position),
        .m_char_out  (m_char_out),
        .m_last_char (m_last_char)
    );

    always #10 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Parser model state: a private copy, kept at the block's widths
    // ------------------------------------------------------------------
    logic       skip_names;     // configuration copy, applied at restart
    logic [1:0] ph;
    logic [1:0] sec;
    logic [6:0] ent;
    logic [7:0] remaining;
    logic [7:0] char_idx;
    logic       discard;

    result_t parsed_q [$];      // results still owed by the DUT

    int  fail_count  = 0;
    int  items_in    = 0;       // accepted input transactions
    int  counted     = 0;       // accepted ones that were not simply ignored
    int  results_ok  = 0;
    int  long_recs   = 0;
    int  cycles      = 0;
    int  cfg_writes  = 0;
    bit  calm        = 1'b0;    // no idling on either side while set

    // Target code page: two shifted ranges and a handful of one-off codes.
    function automatic logic [7:0] code_page_char(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if ((c >= 8'hAE && c <= 8'hC7) || (c >= 8'hCE && c <= 8'hE7))
            r = c - 8'h6D;
        else if (c == 8'hE8)
            r = 8'hA0;
        else if (c == 8'hE9)
            r = 8'h82;
        else if (c >= 8'hEA && c <= 8'hEE)
            r = c - 8'h49;          // EA..EE land on A1..A5
        return r;
    endfunction

    // result stamped with the current section and entry
    function automatic result_t stamp(input logic [1:0] kind, input logic [7:0] pos,
                                      input logic [7:0] ch, input logic last);
        result_t r;
        r.kind      = kind;
        r.section   = sec[0];
        r.entry     = (ent == ENTRY_NONE) ? 6'd0 : ent[5:0];
        r.position  = pos;
        r.char_out  = ch;
        r.last_char = last;
        return r;
    endfunction

    task automatic restart_parse();
        ph        = PH_CODE;
        sec       = skip_names ? SEC_DIALOGUE : SEC_NAME;
        ent       = skip_names ? 7'd0 : ENTRY_NONE;
        remaining = 8'd0;
        char_idx  = 8'd0;
        discard   = 1'b0;
    endtask

    // One accepted byte through the model; at most one result comes out.
    task automatic parse_byte(input logic op, input logic [7:0] b,
                              output bit got, output result_t r);
        logic [6:0] limit;
        logic       last;
        got = 1'b0;
        r   = '0;
        if (!op) begin
            restart_parse();
        end else if (sec != SEC_DONE) begin
            case (ph)
                PH_CODE: begin
                    if (b == CODE_END_SECTION) begin
                        if (sec == SEC_NAME) begin
                            sec = SEC_DIALOGUE;
                            ent = 7'd0;
                        end else begin
                            got = 1'b1;
                            r   = stamp(KIND_END, 8'd0, 8'd0, 1'b0);
                            sec = SEC_DONE;
                        end
                    end else begin
                        if (b == CODE_NEXT_ENTRY) begin
                            if (ent == ENTRY_NONE)
                                ent = 7'd0;
                            else if (ent < ENTRY_SAT)
                                ent = ent + 7'd1;
                        end
                        ph = PH_LEN;
                    end
                end
                PH_LEN: begin
                    limit = (sec == SEC_NAME) ? NAME_LIMIT : DIALOGUE_LIMIT;
                    if (b == 8'd0) begin
                        ph = PH_CODE;
                    end else begin
                        remaining = b;
                        char_idx  = 8'd0;
                        discard   = 1'b0;
                        ph        = PH_CHARS;
                        if (ent == ENTRY_NONE) begin
                            discard = 1'b1;
                            got     = 1'b1;
                            r       = stamp(KIND_MISSING, 8'd0, 8'd0, 1'b0);
                        end else if (ent >= limit) begin
                            discard = 1'b1;
                            got     = 1'b1;
                            r       = stamp(KIND_OVERFLOW, 8'd0, 8'd0, 1'b0);
                        end
                    end
                end
                default: begin
                    last = (remaining <= 8'd1);
                    if (!discard) begin
                        got = 1'b1;
                        r   = stamp(KIND_CHAR, char_idx, code_page_char(b), last);
                    end
                    if (last) begin
                        remaining = 8'd0;
                        char_idx  = 8'd0;
                        discard   = 1'b0;
                        ph        = PH_CODE;
                    end else begin
                        remaining = remaining - 8'd1;
                        char_idx  = char_idx + 8'd1;
                    end
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    function automatic bit take_gap();
        return !calm && ($urandom_range(0, 99) < 31);
    endfunction

    // Offer one transaction, called and returning at a falling edge. With
    // fixed set, the typed expectation replaces the model's own; the model
    // still steps so that its state follows the stream.
    task automatic offer(input logic op, input logic [7:0] b,
                         input bit fixed, input bit has_res, input result_t typed);
        bit      got;
        bit      live;
        result_t r;
        while (take_gap()) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_op      <= op;
        s_in_byte <= b;
        do @(posedge aclk); while (!s_ready);
        live = !op || (sec != SEC_DONE);
        parse_byte(op, b, got, r);
        if (fixed) begin
            if (has_res)
                parsed_q.push_back(typed);
        end else if (got) begin
            parsed_q.push_back(r);
        end
        items_in++;
        if (live)
            counted++;
        @(negedge aclk);
    endtask

    task automatic send_byte(input logic op, input logic [7:0] b);
        offer(op, b, 1'b0, 1'b0, '0);
    endtask

    // Hold the sender until every owed result is back, then let the pipe empty.
    task automatic drain();
        s_valid <= 1'b0;
        while (parsed_q.size() != 0)
            @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_skip(input logic v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we     <= 1'b0;
        skip_names = v;
        cfg_writes++;
    endtask

    // ------------------------------------------------------------------
    // Receiver side: random back-pressure and the result check
    // ------------------------------------------------------------------
    always @(negedge aclk)
        m_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 31);

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d (0x%0h), got %0d (0x%0h)",
                   name, exp_v, exp_v, act_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (parsed_q.size() == 0) begin
                $error("result transaction with nothing owed: kind %0d char 0x%0h",
                       m_kind, m_char_out);
                fail_count++;
            end else begin
                want = parsed_q.pop_front();
                check_field("kind",      want.kind,      m_kind);
                check_field("section",   want.section,   m_section);
                check_field("entry",     want.entry,     m_entry);
                check_field("position",  want.position,  m_position);
                check_field("char_out",  want.char_out,  m_char_out);
                check_field("last_char", want.last_char, m_last_char);
                results_ok++;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycles, parsed_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Random record streams
    // ------------------------------------------------------------------
    function automatic logic [7:0] pick_len();
        int v;
        v = $urandom_range(0, 99);
        if (v < 5)
            return 8'd0;
        else if (v < 90)
            return 8'($urandom_range(1, 8));
        else if (v < 99)
            return 8'($urandom_range(9, 40));
        else
            return 8'($urandom_range(41, 255));
    endfunction

    // character bytes lean towards the remapped part of the code page
    function automatic logic [7:0] pick_char();
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(8'hA0, 8'hF7));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_record(input logic [7:0] code, input logic [7:0] len);
        send_byte(1'b1, code);
        send_byte(1'b1, len);
        for (int i = 0; i < len; i++)
            send_byte(1'b1, pick_char());
    endtask

    task automatic run_phase(input logic skip, input bit force_long);
        int         stop;
        int         roll;
        int         n;
        logic [7:0] code;
        stop = counted + PHASE_QUOTA;
        write_skip(skip);
        // now and then carry on without a restart: the new setting must wait
        if ($urandom_range(0, 3) != 0)
            send_byte(1'b0, 8'($urandom_range(0, 255)));
        if (force_long) begin
            if (sec == SEC_DONE)
                send_byte(1'b0, 8'h00);
            send_record(CODE_NEXT_ENTRY, 8'd255);
            long_recs++;
        end
        while (counted < stop) begin
            roll = $urandom_range(0, 99);
            if (sec == SEC_DONE) begin
                // a few ignored bytes, then a restart
                n = $urandom_range(0, 2);
                for (int i = 0; i < n; i++)
                    send_byte(1'b1, 8'($urandom_range(0, 255)));
                send_byte(1'b0, 8'($urandom_range(0, 255)));
            end else if (roll < 8) begin
                // noise, restarts included: breaks records at any point
                send_byte(($urandom_range(0, 4) == 0) ? 1'b0 : 1'b1,
                          8'($urandom_range(0, 255)));
            end else if (roll < 16) begin
                send_byte(1'b1, CODE_END_SECTION);
            end else if (roll < 24) begin
                // run of empty records to push the entry counter up
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 70)
                                                : $urandom_range(1, 15);
                for (int i = 0; i < n; i++) begin
                    send_byte(1'b1, CODE_NEXT_ENTRY);
                    send_byte(1'b1, 8'd0);
                end
            end else begin
                code = CODE_NEXT_ENTRY;
                if ($urandom_range(0, 3) == 0) begin
                    do code = 8'($urandom_range(0, 255));
                    while (code == CODE_END_SECTION);
                end
                send_record(code, pick_len());
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Directed table: skip_name_section at its reset value
    // ------------------------------------------------------------------
    typedef struct {
        logic       op;
        logic [7:0] data;
        bit         fixed;      // expectation typed in below
        bit         has_res;
        result_t    res;
    } stim_row_t;

    localparam int DIR_ROWS = 23;
    stim_row_t dir_rows [DIR_ROWS];

    function automatic result_t fault(input logic [1:0] kind, input logic section,
                                      input logic [5:0] entry);
        result_t r;
        r           = '0;
        r.kind      = kind;
        r.section   = section;
        r.entry     = entry;
        return r;
    endfunction

    initial begin
        dir_rows = '{
            // before any entry marker: plain code, then a nonempty record
            '{1'b1, 8'h01,            1'b1, 1'b0, '0},
            '{1'b1, 8'h02,            1'b1, 1'b1, fault(KIND_MISSING, 1'b0, 6'd0)},
            '{1'b1, 8'h41,            1'b1, 1'b0, '0},  // dropped
            '{1'b1, 8'h42,            1'b1, 1'b0, '0},  // dropped
            // name entry 0, four characters over the remap edges
            '{1'b1, CODE_NEXT_ENTRY,  1'b1, 1'b0, '0},
            '{1'b1, 8'h04,            1'b1, 1'b0, '0},
            '{1'b1, 8'hAE,            1'b0, 1'b0, '0},
            '{1'b1, 8'hC7,            1'b0, 1'b0, '0},
            '{1'b1, 8'hE9,            1'b0, 1'b0, '0},
            '{1'b1, 8'hFF,            1'b0, 1'b0, '0},
            // empty record, then end of the name section
            '{1'b1, CODE_NEXT_ENTRY,  1'b1, 1'b0, '0},
            '{1'b1, 8'h00,            1'b1, 1'b0, '0},
            '{1'b1, CODE_END_SECTION, 1'b1, 1'b0, '0},
            // dialogue entry 1
            '{1'b1, CODE_NEXT_ENTRY,  1'b1, 1'b0, '0},
            '{1'b1, 8'h02,            1'b1, 1'b0, '0},
            '{1'b1, 8'h00,            1'b0, 1'b0, '0},
            '{1'b1, 8'hEE,            1'b0, 1'b0, '0},
            '{1'b1, CODE_END_SECTION, 1'b1, 1'b1, fault(KIND_END, 1'b1, 6'd1)},
            '{1'b1, 8'h55,            1'b1, 1'b0, '0},  // done: ignored
            // restart, both sections closed straight away
            '{1'b0, 8'hFF,            1'b1, 1'b0, '0},
            '{1'b1, CODE_END_SECTION, 1'b1, 1'b0, '0},
            '{1'b1, CODE_END_SECTION, 1'b1, 1'b1, fault(KIND_END, 1'b1, 6'd0)},
            '{1'b0, 8'h00,            1'b1, 1'b0, '0}
        };

        skip_names = 1'b0;
        restart_parse();

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_rows[i])
            offer(dir_rows[i].op, dir_rows[i].data, dir_rows[i].fixed,
                  dir_rows[i].has_res, dir_rows[i].res);

        // random phases over both settings; the third runs with no idling
        run_phase(1'b1, 1'b0);
        run_phase(1'b0, 1'b1);
        calm = 1'b1;
        run_phase(1'b0, 1'b0);
        calm = 1'b0;
        run_phase(1'b1, 1'b1);
        run_phase(1'b0, 1'b0);
        run_phase(1'b1, 1'b0);

        drain();
        repeat (10) @(posedge aclk);

        $display("%0d input transactions (%0d parsed), %0d results checked",
                 items_in, counted, results_ok);
        $display("%0d skip_name_section writes, %0d full-length records, %0d cycles",
                 cfg_writes, long_recs, cycles);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
